### design/ridt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridt_pkg: shared types and constants for the target tracker
// Table geometry, opcodes, controller states and controller/datapath links.
// ----------------------------------------------------------------------------
package ridt_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam logic [31:0] MAX_AGE_RESET = 32'd10000;
  localparam logic [7:0]  LOC_MIN_LEN   = 8'd19;
  localparam logic [3:0]  MSG_TYPE_LOC  = 4'h1;
  localparam logic [17:0] ALT_K         = 18'd107507;
  localparam logic signed [17:0] ALT_MAX = 18'sd104224;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_SWEEP  = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_TARGET  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_SWEEP,
    ST_EMIT,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic load;     // capture input item, clear scan state
    logic scan;     // examine slot at idx for a report
    logic commit;   // write report into the chosen slot
    logic age;      // examine slot at idx for a sweep
    logic advance;  // step idx
  } ctl_cmd_t;

  typedef struct packed {
    logic last_slot;
    logic emit_hit;  // slot at idx is live and positioned
  } ctl_sts_t;

endpackage

### design/ridt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridt_ctrl: tracker sequencer
// Walks the slots once per item and paces output handshakes.
// ----------------------------------------------------------------------------
module ridt_ctrl import ridt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     in_sweep,
  input  logic     out_busy,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output logic     idle,
  output logic     out_load_target,
  output logic     out_load_summary
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_fire) state_next = in_sweep ? ST_SWEEP : ST_SCAN;
      ST_SCAN:    if (sts.last_slot) state_next = ST_WRITE;
      ST_WRITE:   state_next = ST_IDLE;
      ST_SWEEP:   if (sts.emit_hit) state_next = ST_EMIT;
                  else if (sts.last_slot) state_next = ST_SUMMARY;
      ST_EMIT:    if (!out_busy) state_next = sts.last_slot ? ST_SUMMARY : ST_SWEEP;
      ST_SUMMARY: if (!out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    idle = 1'b0;
    out_load_target = 1'b0;
    out_load_summary = 1'b0;
    unique case (state)
      ST_IDLE:    begin idle = 1'b1; cmd.load = in_fire; end
      ST_SCAN:    begin cmd.scan = 1'b1; cmd.advance = 1'b1; end
      ST_WRITE:   cmd.commit = 1'b1;
      ST_SWEEP:   begin
        cmd.age = 1'b1;
        cmd.advance = !sts.emit_hit;
      end
      ST_EMIT:    if (!out_busy) begin
        out_load_target = 1'b1;
        cmd.advance = 1'b1;
      end
      ST_SUMMARY: out_load_summary = !out_busy;
      default:    ;
    endcase
  end

endmodule

### design/ridt_alt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridt_alt: altitude conversion
// Half-meter raw value to feet, Q16 scale, round half away from zero.
// One registered multiply; result valid the cycle after the operand.
// ----------------------------------------------------------------------------
module ridt_alt import ridt_pkg::*; (
  input  logic               clk,
  input  logic [15:0]        raw,
  output logic signed [17:0] alt_ft
);

  logic        neg;
  logic [15:0] mag;
  logic [33:0] prod;
  logic [33:0] rnd;
  logic [17:0] q;

  always_comb begin
    neg = raw < 16'd2000;
    mag = neg ? (16'd2000 - raw) : (raw - 16'd2000);
  end

  always_ff @(posedge clk) begin
    prod <= mag * ALT_K;
  end

  // sign recovered from the registered magnitude's source via pipeline flop
  logic neg_q;
  always_ff @(posedge clk) neg_q <= neg;

  always_comb begin
    rnd = prod + 34'd32768;
    q = rnd[33:16];
    if (neg_q)                     alt_ft = -$signed(q);
    else if ($signed(q) > ALT_MAX) alt_ft = ALT_MAX;
    else                           alt_ft = $signed(q);
  end

endmodule

### design/ridt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridt_dp: tracker datapath
// Slot table, lookup/victim selection, aging and output staging.
// ----------------------------------------------------------------------------
module ridt_dp import ridt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  input  logic [31:0]        max_age,
  input  logic [47:0]        in_key,
  input  logic [31:0]        in_now,
  input  logic               in_loc_ok,
  input  logic signed [31:0] in_lat,
  input  logic signed [31:0] in_lon,
  input  logic [15:0]        in_alt_raw,
  output logic signed [31:0] cur_lat,
  output logic signed [31:0] cur_lon,
  output logic signed [17:0] cur_alt,
  output logic [CNT_W-1:0]   pos_cnt,
  output logic [CNT_W-1:0]   seen_cnt
);

  logic [TABLE_SLOTS-1:0] in_use;
  logic [TABLE_SLOTS-1:0] has_pos;
  logic [47:0]            key      [TABLE_SLOTS];
  logic signed [31:0]     lat      [TABLE_SLOTS];
  logic signed [31:0]     lon      [TABLE_SLOTS];
  logic signed [17:0]     alt      [TABLE_SLOTS];
  logic [31:0]            seen     [TABLE_SLOTS];

  logic [SLOT_W-1:0] idx;
  logic [47:0]       r_key;
  logic [31:0]       r_now;
  logic              r_loc;
  logic signed [31:0] r_lat, r_lon;
  logic [15:0]       r_alt_raw;

  logic              hit, free_f, old_f;
  logic [SLOT_W-1:0] hit_i, free_i, old_i;
  logic [31:0]       old_t;
  logic signed [17:0] alt_ft;

  ridt_alt u_alt (.clk(clk), .raw(r_alt_raw), .alt_ft(alt_ft));

  logic live, stale;
  always_comb begin
    stale = (r_now - seen[idx]) > max_age;
    live  = in_use[idx] && !stale;
    sts.last_slot = idx == SLOT_W'(TABLE_SLOTS - 1);
    sts.emit_hit  = live && has_pos[idx];
    cur_lat = lat[idx];
    cur_lon = lon[idx];
    cur_alt = alt[idx];
  end

  logic [SLOT_W-1:0] tgt;
  always_comb begin
    if (hit)         tgt = hit_i;
    else if (free_f) tgt = free_i;
    else             tgt = old_i;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_key <= in_key; r_now <= in_now; r_loc <= in_loc_ok;
      r_lat <= in_lat; r_lon <= in_lon; r_alt_raw <= in_alt_raw;
    end
    if (cmd.scan && !hit) begin
      if (in_use[idx] && key[idx] == r_key) begin
        hit_i <= idx;
      end else if (!in_use[idx]) begin
        if (!free_f) free_i <= idx;
      end else if (!old_f || seen[idx] < old_t) begin
        old_t <= seen[idx]; old_i <= idx;
      end
    end
    if (cmd.commit) begin
      key[tgt]  <= r_key;
      seen[tgt] <= r_now;
      if (r_loc) begin
        lat[tgt] <= r_lat; lon[tgt] <= r_lon; alt[tgt] <= alt_ft;
      end else if (!hit) begin
        lat[tgt] <= '0; lon[tgt] <= '0; alt[tgt] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0; has_pos <= '0; idx <= '0;
      hit <= 1'b0; free_f <= 1'b0; old_f <= 1'b0;
      pos_cnt <= '0; seen_cnt <= '0;
    end else begin
      if (cmd.load) begin
        idx <= '0; hit <= 1'b0; free_f <= 1'b0; old_f <= 1'b0;
        pos_cnt <= '0; seen_cnt <= '0;
      end else if (cmd.advance) begin
        idx <= sts.last_slot ? '0 : idx + 1'b1;
      end
      if (cmd.scan && !hit) begin
        if (in_use[idx] && key[idx] == r_key) hit <= 1'b1;
        else if (!in_use[idx]) free_f <= 1'b1;
        else old_f <= 1'b1;
      end
      if (cmd.commit) begin
        in_use[tgt] <= 1'b1;
        if (r_loc) has_pos[tgt] <= 1'b1;
        else if (!hit) has_pos[tgt] <= 1'b0;
      end
      // a live positioned slot is counted on its hit cycle, which holds idx
      if (cmd.age && cmd.advance && in_use[idx]) begin
        if (stale) in_use[idx] <= 1'b0;
        else begin
          seen_cnt <= seen_cnt + 1'b1;
        end
      end
      if (cmd.age && sts.emit_hit) begin
        seen_cnt <= seen_cnt + 1'b1;
        pos_cnt  <= pos_cnt + 1'b1;
      end
    end
  end

endmodule

### design/remote_id_target_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_id_target_tracker: keyed drone table with aging
// A report walks all 16 slots one per cycle, then writes the chosen slot.
// A sweep walks the slots once, one per cycle, pausing in an emit state per
// positioned target result and in a summary state at the end; output
// back-pressure holds either. The slot scan sets the rate.
module remote_id_target_tracker import ridt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] opcode [48:1] source_key [80:49] now_ms [81] msg_present
  // [89:82] msg_length [97:90] msg_header [129:98] latitude_raw
  // [161:130] longitude_raw [177:162] geodetic_alt_raw [193:178] height_raw
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] target_latitude [63:32] target_longitude [81:64] target_alt_ft
  // [86:82] positioned_count [91:87] tracked_count
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tuser,  // [0] result_kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  logic [31:0] max_age;
  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic idle, ld_t, ld_s, in_fire;
  logic signed [31:0] cur_lat, cur_lon;
  logic signed [17:0] cur_alt;
  logic [CNT_W-1:0] pos_cnt, seen_cnt;
  logic [15:0] alt_raw;
  logic loc_ok;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_age <= MAX_AGE_RESET;
    else if (cfg_valid) max_age <= cfg_data;
  end

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign alt_raw = (s_axis_tdata[193:178] != 16'd0) ? s_axis_tdata[193:178]
                                                    : s_axis_tdata[177:162];
  assign loc_ok = s_axis_tdata[81] && (s_axis_tdata[89:82] >= LOC_MIN_LEN) &&
                  (s_axis_tdata[97:94] == MSG_TYPE_LOC) &&
                  (s_axis_tdata[129:98] != 32'd0 || s_axis_tdata[161:130] != 32'd0);

  ridt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_sweep(s_axis_tdata[0] == OP_SWEEP), .out_busy(m_axis_tvalid && !m_axis_tready),
    .sts(sts), .cmd(cmd), .idle(idle),
    .out_load_target(ld_t), .out_load_summary(ld_s)
  );

  ridt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .max_age(max_age),
    .in_key(s_axis_tdata[48:1]), .in_now(s_axis_tdata[80:49]), .in_loc_ok(loc_ok),
    .in_lat(s_axis_tdata[129:98]), .in_lon(s_axis_tdata[161:130]),
    .in_alt_raw(alt_raw), .cur_lat(cur_lat), .cur_lon(cur_lon), .cur_alt(cur_alt),
    .pos_cnt(pos_cnt), .seen_cnt(seen_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (ld_t || ld_s) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ld_t) begin
      m_axis_tdata <= {4'd0, 10'd0, 18'(cur_alt), cur_lon, cur_lat};
      m_axis_tuser <= KIND_TARGET;
      m_axis_tlast <= 1'b0;
    end else if (ld_s) begin
      m_axis_tdata <= {4'd0, 5'(seen_cnt), 5'(pos_cnt), 82'd0};
      m_axis_tuser <= KIND_SUMMARY;
      m_axis_tlast <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !(ld_t || ld_s))
    else $error("result overwritten while stalled");
  a_tlast_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tlast == m_axis_tuser)
    else $error("tlast and kind disagree");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    idle |-> !(ld_t || ld_s))
    else $error("output load while idle");
`endif

endmodule
